@@ hdl/acu_pkg.sv @@
// ----------------------------------------------------------------------------
// acu_pkg: shared types, codes and GF(2^8) helpers
// Operation codes, lane result type, byte-field arithmetic over x^8+x^4+x^3+x+1
// and the multiplicative inverse table built at elaboration.
// ----------------------------------------------------------------------------
package acu_pkg;

    localparam int unsigned LANES = 4;

    localparam logic [7:0] POLY_LOW = 8'h1B;

    typedef enum logic [2:0] {
        KIND_MIXCOL = 3'd0,
        KIND_INVMIX = 3'd1,
        KIND_MUL    = 3'd2,
        KIND_INV    = 3'd3,
        KIND_ROTL   = 3'd4,
        KIND_ROTR   = 3'd5
    } t_kind;

    typedef logic [7:0] t_byte;
    typedef t_byte t_col [LANES];
    typedef t_byte t_byte_tab [256];

    typedef struct packed {
        t_byte fwd;
        t_byte inv;
    } t_lane_out;

    function automatic t_byte xtime(input t_byte a);
        return {a[6:0], 1'b0} ^ (a[7] ? POLY_LOW : 8'h00);
    endfunction

    function automatic t_byte gf_mul(input t_byte a, input t_byte b);
        t_byte acc;
        t_byte x;
        acc = 8'h00;
        x   = a;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) begin
                acc = acc ^ x;
            end
            x = xtime(x);
        end
        return acc;
    endfunction

    // x^254 by square-and-multiply; zero maps to zero
    function automatic t_byte gf_inv_calc(input t_byte a);
        t_byte res;
        t_byte base;
        logic [7:0] e;
        res  = 8'h01;
        base = a;
        e    = 8'd254;
        for (int i = 0; i < 8; i++) begin
            if (e[i]) begin
                res = gf_mul(res, base);
            end
            base = gf_mul(base, base);
        end
        return res;
    endfunction

    function automatic t_byte_tab build_inv_tab();
        t_byte_tab tab;
        for (int i = 0; i < 256; i++) begin
            tab[i] = gf_inv_calc(t_byte'(i));
        end
        return tab;
    endfunction

    localparam t_byte_tab INV_TAB = build_inv_tab();

endpackage

@@ hdl/acu_lane.sv @@
// ----------------------------------------------------------------------------
// acu_lane: one row of the column matrix product
// Produces the forward (2,3,1,1) and inverse (14,11,13,9) mix byte for one
// row; byte 0 of the input is the row's own byte, the rest follow cyclically.
// ----------------------------------------------------------------------------
module acu_lane
    import acu_pkg::*;
(
    input  t_col      i_col,
    output t_lane_out o_lane
);

    t_byte x2 [LANES];
    t_byte x4 [LANES];
    t_byte x8 [LANES];

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            x2[k] = xtime(i_col[k]);
            x4[k] = xtime(x2[k]);
            x8[k] = xtime(x4[k]);
        end
    end

    always_comb begin
        o_lane.fwd = x2[0] ^ (x2[1] ^ i_col[1]) ^ i_col[2] ^ i_col[3];
        o_lane.inv = (x8[0] ^ x4[0] ^ x2[0])
                   ^ (x8[1] ^ x2[1] ^ i_col[1])
                   ^ (x8[2] ^ x4[2] ^ i_col[2])
                   ^ (x8[3] ^ i_col[3]);
    end

endmodule

@@ hdl/acu_merge.sv @@
// ----------------------------------------------------------------------------
// acu_merge: result assembly
// Gathers the lane bytes into a column, computes the byte multiply, the
// inverse lookup and the rotations, and selects by operation code.
// ----------------------------------------------------------------------------
module acu_merge
    import acu_pkg::*;
(
    input  t_kind       i_kind,
    input  logic [31:0] i_word,
    input  t_byte       i_operand_b,
    input  t_lane_out   i_lanes [LANES],
    output logic [31:0] o_result
);

    logic [31:0] fwd_col;
    logic [31:0] inv_col;
    t_byte       mul_byte;
    t_byte       inv_byte;

    always_comb begin
        for (int r = 0; r < LANES; r++) begin
            fwd_col[31 - 8 * r -: 8] = i_lanes[r].fwd;
            inv_col[31 - 8 * r -: 8] = i_lanes[r].inv;
        end
    end

    assign mul_byte = gf_mul(i_word[7:0], i_operand_b);
    assign inv_byte = INV_TAB[i_word[7:0]];

    always_comb begin
        case (i_kind)
            KIND_MIXCOL: o_result = fwd_col;
            KIND_INVMIX: o_result = inv_col;
            KIND_MUL:    o_result = {24'h000000, mul_byte};
            KIND_INV:    o_result = {24'h000000, inv_byte};
            KIND_ROTL:   o_result = {i_word[23:0], i_word[31:24]};
            KIND_ROTR:   o_result = {i_word[7:0], i_word[31:8]};
            default:     o_result = 32'h00000000;
        endcase
    end

endmodule

@@ hdl/aes_gf256_column_unit_core.sv @@
// ----------------------------------------------------------------------------
// aes_gf256_column_unit_core: AES column and field arithmetic unit
// Four row lanes compute the MixColumns/InvMixColumns bytes in parallel; the
// merge logic adds multiply, inverse and rotate, and the core registers the result.
//
//   channel  | dir | tdata                             | tuser
//   s stream | in  | [31:0] word, [39:32] operand_b    | [2:0] kind
//   m stream | out | [31:0] result                     | -
//
// One beat per cycle while the output is not stalled; each result appears in the cycle after its input beat.
// The lane/merge logic is combinational; its result is held in the single output register.
// Input is taken whenever the output register is empty or being drained.
// Stalls on the output hold the result and backpressure the input.
// Reset clears the output valid only; there is no other state.
// ----------------------------------------------------------------------------
module aes_gf256_column_unit_core
    import acu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // [31:0] word, [39:32] operand_b
    input  logic [2:0]  i_s_tuser,   // [2:0] kind
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata    // [31:0] result
);

    logic [31:0] word;
    t_byte       operand_b;
    t_kind       kind;
    t_col        lane_col [LANES];
    t_lane_out   lanes    [LANES];
    logic [31:0] merged;
    logic        take;

    logic        r_valid;
    logic        n_valid;
    logic [31:0] r_result;

    assign word      = i_s_tdata[31:0];
    assign operand_b = i_s_tdata[39:32];
    assign kind      = t_kind'(i_s_tuser);

    for (genvar r = 0; r < LANES; r++) begin : g_lane
        for (genvar k = 0; k < LANES; k++) begin : g_byte
            assign lane_col[r][k] = word[31 - 8 * ((r + k) % LANES) -: 8];
        end
        acu_lane u_lane (
            .i_col  (lane_col[r]),
            .o_lane (lanes[r])
        );
    end

    acu_merge u_merge (
        .i_kind      (kind),
        .i_word      (word),
        .i_operand_b (operand_b),
        .i_lanes     (lanes),
        .o_result    (merged)
    );

    assign o_s_tready = !r_valid || i_m_tready;
    assign take       = i_s_tvalid && o_s_tready;

    always_comb begin
        n_valid = r_valid;
        if (take) begin
            n_valid = 1'b1;
        end else if (i_m_tready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // load on every accepted beat; hold otherwise
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_result <= merged;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_result;

endmodule

@@ hdl/acu_checker.sv @@
// ----------------------------------------------------------------------------
// acu_checker: port-level checks for the column unit
// Watches the stream ports and checks stall behavior and a few result cases.
// ----------------------------------------------------------------------------
module acu_checker
    import acu_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [39:0] i_s_tdata,
    input logic [2:0]  i_s_tuser,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [31:0] o_m_tdata
);

    logic s_beat;
    assign s_beat = i_s_tvalid && o_s_tready;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    a_rotl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_beat && i_s_tuser == KIND_ROTL |=> o_m_tvalid
            && o_m_tdata == {$past(i_s_tdata[23:0]), $past(i_s_tdata[31:24])})
        else $error("rotate left result wrong");

    a_unused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_beat && (i_s_tuser == 3'd6 || i_s_tuser == 3'd7)
            |=> o_m_tvalid && o_m_tdata == 32'h00000000)
        else $error("unused code gave nonzero result");

    a_inv0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_beat && i_s_tuser == KIND_INV && i_s_tdata[7:0] == 8'h00
            |=> o_m_tvalid && o_m_tdata == 32'h00000000)
        else $error("inverse of zero not zero");

    a_mul1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_beat && i_s_tuser == KIND_MUL && i_s_tdata[39:32] == 8'h01
            |=> o_m_tvalid && o_m_tdata == {24'h000000, $past(i_s_tdata[7:0])})
        else $error("multiply by one wrong");

endmodule

bind aes_gf256_column_unit_core acu_checker u_acu_checker (.*);
